[hdl/rhht_pkg.sv]
// ---------------------------------------------------------------------------
// Relocating hash handle table package
// Shared types and constants for the handle table and its slot hash unit.
// ---------------------------------------------------------------------------
package rhht_pkg;

    localparam logic [63:0] HASH_MUL = 64'd2654435769;

    localparam logic [1:0] ST_FREE     = 2'd0;
    localparam logic [1:0] ST_OCCUPIED = 2'd1;
    localparam logic [1:0] ST_FORWARD  = 2'd2;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SET    = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;
    localparam logic [1:0] OP_REMOVE = 2'd3;

    localparam logic [13:0] VALUE_NONE = 14'h3FFF;

    typedef logic [5:0] level_t;

endpackage

[hdl/rhht_ram.sv]
// ---------------------------------------------------------------------------
// Generic single-port RAM
// One write or read per cycle; the read data is registered.
// ---------------------------------------------------------------------------
module rhht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[hdl/rhht_hash.sv]
// ---------------------------------------------------------------------------
// Slot hash multiplier
// Multiplies the key by the golden-ratio constant in 16-bit partial
// products, one per cycle, keeping the low 64 bits of the product.
// ---------------------------------------------------------------------------
module rhht_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] key,
    output logic        done,
    output logic [63:0] product
);

    logic [63:0] key_reg, key_next;
    logic [63:0] acc_reg, acc_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic [47:0] part;

    // Only the low 32 bits of the constant are non-zero.
    always_comb
    begin
        part     = 48'(key_reg[15:0]) * 48'(rhht_pkg::HASH_MUL[31:0]);
        key_next = key_reg;
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        done     = 1'b0;
        if (start)
        begin
            key_next = key;
            acc_next = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            acc_next = acc_reg + (64'(part) << {cnt_reg[1:0], 4'd0});
            key_next = {16'd0, key_reg[63:16]};
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd3)
            begin
                run_next = 1'b0;
            end
        end
        else if (cnt_reg == 3'd4)
        begin
            done     = 1'b1;
            cnt_next = '0;
        end
    end

    assign product = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        acc_reg <= acc_next;
    end

endmodule

[hdl/relocating_hash_handle_table.sv]
// ---------------------------------------------------------------------------
// Relocating hash handle table
// Handle table with forward marks and relocation of displaced entries.
// ---------------------------------------------------------------------------
// Each probed level takes a hash, a table read and a write; an insert
// can walk and relocate through every level.
// One word at a time: busy is high from acceptance until the result strobe.
// The hash multiplier and the single table port limit its speed.
// After reset the block clears every table row (key, value and status), one
// slot a cycle, holding busy high; the receiver cannot stall.
module relocating_hash_handle_table #(
    parameter int TABLE_SLOTS = 2048,
    parameter int MAX_LEVEL   = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         opcode,
    input  logic [63:0]        key,
    input  logic signed [13:0] new_value,
    output logic               done,
    output logic signed [13:0] found_value,
    output logic [10:0]        slot_index,
    output logic               hit,
    output logic               level_overflow
);

    localparam int AW = $clog2(TABLE_SLOTS);
    localparam int SD = MAX_LEVEL + 1;
    localparam int SW = $clog2(SD + 1);
    localparam int SAW = $clog2(SD);
    // Row width: key, value, status all in one memory word.
    localparam int RW = 64 + 14 + 2;
    // Stack word: key, level, value and carry flag.
    localparam int KW = 64 + 6 + 14 + 1;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_HASH   = 4'd2;
    localparam logic [3:0] S_WAIT   = 4'd3;
    localparam logic [3:0] S_READ   = 4'd4;
    localparam logic [3:0] S_RDATA  = 4'd5;
    localparam logic [3:0] S_DECIDE = 4'd6;
    localparam logic [3:0] S_DONE   = 4'd7;
    localparam logic [3:0] S_POP    = 4'd8;

    logic [3:0]  state_reg, state_next;
    logic [AW:0] clr_reg, clr_next;
    logic [1:0]  op_reg, op_next;
    logic [63:0] ikey_reg, ikey_next;
    logic [13:0] nv_reg, nv_next;
    logic [SW-1:0] sp_reg, sp_next;
    logic [63:0] cur_key_reg, cur_key_next;
    logic [5:0]  cur_lv_reg, cur_lv_next;
    logic [13:0] cur_val_reg, cur_val_next;
    logic        cur_car_reg, cur_car_next;
    logic [AW-1:0] h_reg, h_next;
    logic [AW-1:0] last_reg, last_next;
    logic        done_reg, done_next;
    logic [13:0] fv_reg, fv_next;
    logic [10:0] si_reg, si_next;
    logic        hit_reg, hit_next, ovf_reg, ovf_next;

    // Relocation stack: one word per parked entry, held in a small RAM.
    logic           push, pop_load;
    logic [SAW-1:0] stk_addr;
    logic [KW-1:0]  stk_wdata, stk_rdata;

    logic        hash_go, hash_done;
    logic [63:0] product;
    logic [AW-1:0] slot_calc;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [RW-1:0] ram_wdata, ram_rdata;
    logic [RW-1:0] row_reg, row_next;
    logic [63:0]   row_key;
    logic [13:0]   row_val;
    logic [1:0]    row_st;

    rhht_hash u_hash (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (hash_go),
        .key     (cur_key_reg),
        .done    (hash_done),
        .product (product)
    );

    rhht_ram #(.WIDTH(RW), .DEPTH(TABLE_SLOTS)) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Stack slot sp-2 holds the word that is parked beneath the current one.
    // A pop reads slot sp-2, and the word arrives in the following cycle.
    rhht_ram #(.WIDTH(KW), .DEPTH(SD)) u_stack (
        .clk   (clk),
        .we    (push),
        .addr  (stk_addr),
        .wdata (stk_wdata),
        .rdata (stk_rdata)
    );

    assign stk_addr  = pop_load ? SAW'(sp_reg - SW'(2)) : SAW'(sp_reg - SW'(1));
    assign stk_wdata = {cur_key_reg, cur_lv_reg, cur_val_reg, cur_car_reg};

    // Level shift is at most 32 steps of a 64-bit word: one barrel shifter.
    assign slot_calc = AW'(product >> (7'd32 - 7'(cur_lv_reg)));

    assign row_key = row_reg[RW-1 -: 64];
    assign row_val = row_reg[15:2];
    assign row_st  = row_reg[1:0];

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        op_next      = op_reg;
        ikey_next    = ikey_reg;
        nv_next      = nv_reg;
        sp_next      = sp_reg;
        cur_key_next = cur_key_reg;
        cur_lv_next  = cur_lv_reg;
        cur_val_next = cur_val_reg;
        cur_car_next = cur_car_reg;
        h_next       = h_reg;
        last_next    = last_reg;
        row_next     = row_reg;
        done_next    = 1'b0;
        fv_next      = fv_reg;
        si_next      = si_reg;
        hit_next     = hit_reg;
        ovf_next     = ovf_reg;
        hash_go      = 1'b0;
        ram_we       = 1'b0;
        ram_addr     = h_reg;
        ram_wdata    = row_reg;
        push         = 1'b0;
        pop_load     = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg[AW-1:0];
                ram_wdata = {64'd0, rhht_pkg::VALUE_NONE, rhht_pkg::ST_FREE};
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(TABLE_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op_next      = opcode;
                    ikey_next    = key;
                    nv_next      = new_value;
                    cur_key_next = key;
                    cur_lv_next  = '0;
                    cur_val_next = rhht_pkg::VALUE_NONE;
                    cur_car_next = 1'b0;
                    sp_next      = SW'(1);
                    state_next   = S_HASH;
                end
            end
            S_HASH:
            begin
                hash_go    = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (hash_done)
                begin
                    h_next     = slot_calc;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_RDATA;
            end
            S_RDATA:
            begin
                row_next   = ram_rdata;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_HASH;
                if (op_reg != rhht_pkg::OP_INSERT)
                begin
                    if (row_st == rhht_pkg::ST_FORWARD)
                    begin
                        if (cur_lv_reg >= 6'(MAX_LEVEL))
                        begin
                            ovf_next = 1'b1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cur_lv_next = cur_lv_reg + 6'd1;
                        end
                    end
                    else
                    begin
                        ovf_next   = 1'b0;
                        state_next = S_DONE;
                        hit_next   = (row_key == ikey_reg) &&
                                     (row_st == rhht_pkg::ST_OCCUPIED);
                        fv_next    = '0;
                        unique case (op_reg)
                            rhht_pkg::OP_SET:
                            begin
                                if (hit_next)
                                begin
                                    ram_we    = 1'b1;
                                    ram_wdata = {row_key, nv_reg, row_st};
                                end
                            end
                            rhht_pkg::OP_LOOKUP:
                            begin
                                fv_next = (row_key == ikey_reg) ? row_val
                                                                : rhht_pkg::VALUE_NONE;
                            end
                            default:
                            begin
                                if (row_st == rhht_pkg::ST_OCCUPIED)
                                begin
                                    ram_we    = 1'b1;
                                    ram_wdata = {row_key, row_val, rhht_pkg::ST_FREE};
                                end
                            end
                        endcase
                        last_next = h_reg;
                    end
                end
                else if (row_st == rhht_pkg::ST_FORWARD)
                begin
                    if (cur_lv_reg >= 6'(MAX_LEVEL))
                    begin
                        ovf_next   = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cur_lv_next = cur_lv_reg + 6'd1;
                    end
                end
                else if (row_st == rhht_pkg::ST_OCCUPIED)
                begin
                    if (cur_lv_reg >= 6'(MAX_LEVEL) || sp_reg >= SW'(SD))
                    begin
                        ovf_next   = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // Park the current word and chase the displaced one.
                        ram_we       = 1'b1;
                        ram_wdata    = {row_key, row_val, rhht_pkg::ST_FORWARD};
                        push         = 1'b1;
                        cur_key_next = row_key;
                        cur_lv_next  = cur_lv_reg + 6'd1;
                        cur_val_next = row_val;
                        cur_car_next = 1'b1;
                        sp_next      = sp_reg + 1'b1;
                    end
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_wdata = {cur_key_reg, cur_car_reg ? cur_val_reg : row_val,
                                 rhht_pkg::ST_OCCUPIED};
                    last_next = h_reg;
                    sp_next   = sp_reg - 1'b1;
                    if (sp_reg == SW'(1))
                    begin
                        ovf_next   = 1'b0;
                        hit_next   = 1'b1;
                        fv_next    = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        pop_load   = 1'b1;
                        state_next = S_POP;
                    end
                end
            end
            S_POP:
            begin
                // The parked word read in the previous cycle becomes current.
                cur_key_next = stk_rdata[KW-1 -: 64];
                cur_lv_next  = stk_rdata[20:15];
                cur_val_next = stk_rdata[14:1];
                cur_car_next = stk_rdata[0];
                state_next   = S_HASH;
            end
            S_DONE:
            begin
                done_next  = 1'b1;
                if (ovf_reg)
                begin
                    hit_next = 1'b0;
                    fv_next  = '0;
                    si_next  = '0;
                end
                else
                begin
                    si_next = 11'(last_reg);
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        ikey_reg    <= ikey_next;
        nv_reg      <= nv_next;
        cur_key_reg <= cur_key_next;
        cur_lv_reg  <= cur_lv_next;
        cur_val_reg <= cur_val_next;
        cur_car_reg <= cur_car_next;
        h_reg       <= h_next;
        last_reg    <= last_next;
        row_reg     <= row_next;
        fv_reg      <= fv_next;
        si_reg      <= si_next;
        hit_reg     <= hit_next;
        ovf_reg     <= ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            sp_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            sp_reg    <= sp_next;
            done_reg  <= done_next;
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign found_value    = fv_reg;
    assign slot_index     = si_reg;
    assign hit            = hit_reg;
    assign level_overflow = ovf_reg & done_reg;

    // A result word strobes only just after the closing state.
    a_done_after_close: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == S_DONE)
        else $error("result strobe without a closing state");

    // The relocation stack never grows beyond its depth.
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SW'(SD))
        else $error("relocation stack overrun");

    // The table is never written while the block waits for work.
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !ram_we)
        else $error("table written while idle");

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Relocating hash handle table testbench
// Drives a table of directed words, then about 850 random words, into the
// handle table. An in-bench model of the slot memory predicts the result words
// that the directed table leaves open; each strobe is checked field by field.
// ---------------------------------------------------------------------------
module testbench;

    localparam int  SLOTS       = 2048;
    localparam int  DEEPEST     = 32;
    localparam int  RANDOM_WORDS = 850;
    localparam int  CALM_WORDS  = 120;
    localparam int  CYCLE_LIMIT = 40000000;

    typedef struct packed {
        logic signed [13:0] found;
        logic [10:0]        slot;
        logic               hit;
        logic               ovf;
    } answer_t;

    typedef struct {
        logic [1:0]  op;
        logic [63:0] k;
        logic [13:0] nv;
        bit          typed;
        answer_t     ans;
    } directed_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         opcode;
    logic [63:0]        key;
    logic signed [13:0] new_value;
    logic               done;
    logic signed [13:0] found_value;
    logic [10:0]        slot_index;
    logic               hit;
    logic               level_overflow;

    // Mirror of the slot memory. The written flags record which slot keys
    // hold a real key, so that no probe ever compares against a key the
    // block has never stored.
    logic [63:0] mirror_keys [SLOTS];
    logic [13:0] mirror_vals [SLOTS];
    logic [1:0]  mirror_stat [SLOTS];
    bit          key_written [SLOTS];

    answer_t     pending_answers[$];
    directed_t   directed_words[$];
    logic [63:0] recent_keys[$];
    int          fault_count;
    int          cycle_count;

    relocating_hash_handle_table uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .key            (key),
        .new_value      (new_value),
        .done           (done),
        .found_value    (found_value),
        .slot_index     (slot_index),
        .hit            (hit),
        .level_overflow (level_overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Slot of a key at a given level: bits taken from the 64-bit product
    // after shifting right by 32 minus the level.
    function automatic logic [10:0] hash_slot(input logic [63:0] k, input int lv);
        logic [63:0] prod;
        prod = k * rhht_pkg::HASH_MUL;
        prod = prod >> (32 - lv);
        return prod[10:0];
    endfunction

    // Walk over forward marks from level zero; returns 0 on level overflow.
    function automatic bit walk_forwards(input logic [63:0] k, output logic [10:0] s);
        for (int lv = 0; lv <= DEEPEST; lv++)
        begin
            s = hash_slot(k, lv);
            if (mirror_stat[s] != rhht_pkg::ST_FORWARD)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Insert with relocation. Each displaced entry is pushed onto a stack
    // with its value and sent one level deeper; the new key itself keeps
    // whatever stale value its slot already held.
    task automatic table_insert(input logic [63:0] k, output bit ok, output logic [10:0] s);
        logic [63:0] stk_key [DEEPEST+1];
        int          stk_lvl [DEEPEST+1];
        logic [13:0] stk_val [DEEPEST+1];
        bit          stk_carry [DEEPEST+1];
        int          sp;
        int          t;
        int          lv;
        logic [10:0] h;
        sp = 1;
        stk_key[0] = k;
        stk_lvl[0] = 0;
        stk_val[0] = rhht_pkg::VALUE_NONE;
        stk_carry[0] = 1'b0;
        ok = 1'b1;
        s = '0;
        while (sp > 0 && ok)
        begin
            t = sp - 1;
            lv = stk_lvl[t];
            h = hash_slot(stk_key[t], lv);
            if (mirror_stat[h] == rhht_pkg::ST_FORWARD)
            begin
                if (lv >= DEEPEST)
                    ok = 1'b0;
                else
                    stk_lvl[t] = lv + 1;
            end
            else if (mirror_stat[h] == rhht_pkg::ST_OCCUPIED)
            begin
                if (lv >= DEEPEST || sp >= DEEPEST + 1)
                    ok = 1'b0;
                else
                begin
                    mirror_stat[h] = rhht_pkg::ST_FORWARD;
                    stk_key[sp] = mirror_keys[h];
                    stk_lvl[sp] = lv + 1;
                    stk_val[sp] = mirror_vals[h];
                    stk_carry[sp] = 1'b1;
                    sp++;
                end
            end
            else
            begin
                mirror_stat[h] = rhht_pkg::ST_OCCUPIED;
                mirror_keys[h] = stk_key[t];
                key_written[h] = 1'b1;
                if (stk_carry[t])
                    mirror_vals[h] = stk_val[t];
                s = h;
                sp--;
            end
        end
        if (!ok)
            s = '0;
    endtask

    // Works out the result word of one accepted word and updates the mirror.
    task automatic table_operation(input logic [1:0] op, input logic [63:0] k,
                                   input logic [13:0] nv, output answer_t r);
        bit          ok;
        bit          match;
        bit          live;
        logic [10:0] s;
        r = '0;
        if (op == rhht_pkg::OP_INSERT)
            table_insert(k, ok, s);
        else
            ok = walk_forwards(k, s);
        if (!ok)
        begin
            r.ovf = 1'b1;
        end
        else if (op == rhht_pkg::OP_INSERT)
        begin
            r.slot = s;
            r.hit = 1'b1;
        end
        else
        begin
            r.slot = s;
            match = (mirror_keys[s] == k);
            live = (mirror_stat[s] == rhht_pkg::ST_OCCUPIED);
            r.hit = match && live;
            if (op == rhht_pkg::OP_SET && match && live)
                mirror_vals[s] = nv;
            else if (op == rhht_pkg::OP_LOOKUP)
                r.found = match ? mirror_vals[s] : rhht_pkg::VALUE_NONE;
            else if (op == rhht_pkg::OP_REMOVE && live)
                mirror_stat[s] = rhht_pkg::ST_FREE;
        end
    endtask

    // A probing word that would land on a slot whose key was never stored
    // is turned into an insert instead.
    function automatic bit unstored_probe(input logic [1:0] op, input logic [63:0] k);
        logic [10:0] s;
        if (op == rhht_pkg::OP_INSERT)
            return 1'b0;
        if (!walk_forwards(k, s))
            return 1'b0;
        return !key_written[s];
    endfunction

    // Presents one word and holds it until the block takes it. The
    // expectation is queued first, so it is always waiting when the
    // strobe comes back.
    task automatic send_word(input logic [1:0] op, input logic [63:0] k,
                             input logic [13:0] nv, input bit typed, input answer_t typed_ans);
        answer_t ans;
        if (unstored_probe(op, k))
            op = rhht_pkg::OP_INSERT;
        table_operation(op, k, nv, ans);
        pending_answers.push_back(typed ? typed_ans : ans);
        start <= 1'b1;
        opcode <= op;
        key <= k;
        new_value <= nv;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic idle_burst(input bit allowed);
        if (allowed && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 19))
                @(posedge clk);
        end
    endtask

    task automatic add_row(input logic [1:0] op, input logic [63:0] k, input int nv,
                           input bit typed, input int f, input int s, input bit h, input bit o);
        directed_t row;
        row.op = op;
        row.k = k;
        row.nv = nv[13:0];
        row.typed = typed;
        row.ans.found = f[13:0];
        row.ans.slot = s[10:0];
        row.ans.hit = h;
        row.ans.ovf = o;
        directed_words.push_back(row);
    endtask

    // Random keys are mostly drawn from families that differ only above
    // a chosen bit, so that they share slots from some level onward and
    // force relocation chains; a few are plain random.
    function automatic logic [63:0] pick_key(input logic [63:0] family_base);
        logic [63:0] k;
        if (recent_keys.size() > 0 && $urandom_range(0, 9) < 6)
            return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        if ($urandom_range(0, 9) == 0)
            k = {$urandom, $urandom};
        else
            k = family_base + (64'($urandom_range(0, 15)) << $urandom_range(36, 43));
        recent_keys.push_back(k);
        if (recent_keys.size() > 48)
            void'(recent_keys.pop_front());
        return k;
    endfunction

    // Result checker: results cannot be held off, so each strobe is
    // compared with the oldest expectation at the edge that ends it.
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && done)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("%0t: result word with nothing expected", $time);
                fault_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (found_value !== want.found)
                begin
                    $display("%0t: found_value expected %0d actual %0d",
                             $time, want.found, found_value);
                    fault_count++;
                end
                if (slot_index !== want.slot)
                begin
                    $display("%0t: slot_index expected %0d actual %0d",
                             $time, want.slot, slot_index);
                    fault_count++;
                end
                if (hit !== want.hit)
                begin
                    $display("%0t: hit expected %0b actual %0b", $time, want.hit, hit);
                    fault_count++;
                end
                if (level_overflow !== want.ovf)
                begin
                    $display("%0t: level_overflow expected %0b actual %0b",
                             $time, want.ovf, level_overflow);
                    fault_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [63:0] family_base;
        logic [1:0]  op;
        int          pick;
        answer_t     none;
        none = '0;
        fault_count = 0;
        cycle_count = 0;
        rst_n = 1'b0;
        start = 1'b0;
        opcode = rhht_pkg::OP_INSERT;
        key = '0;
        new_value = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            mirror_keys[i] = '0;
            mirror_vals[i] = rhht_pkg::VALUE_NONE;
            mirror_stat[i] = rhht_pkg::ST_FREE;
            key_written[i] = 1'b0;
        end

        // Key zero hashes to slot zero at every level, which makes its
        // results easy to write down: a second copy can never find room.
        add_row(rhht_pkg::OP_INSERT, 64'd0, 0, 1, 0, 0, 1, 0);
        add_row(rhht_pkg::OP_SET,    64'd0, 8191, 1, 0, 0, 1, 0);
        add_row(rhht_pkg::OP_LOOKUP, 64'd0, 0, 1, 8191, 0, 1, 0);
        add_row(rhht_pkg::OP_REMOVE, 64'd0, 0, 1, 0, 0, 1, 0);
        // A freed slot still answers a lookup with its stale value.
        add_row(rhht_pkg::OP_LOOKUP, 64'd0, 0, 1, 8191, 0, 0, 0);
        add_row(rhht_pkg::OP_SET,    64'd0, -1, 1, 0, 0, 0, 0);
        add_row(rhht_pkg::OP_INSERT, 64'd0, 0, 1, 0, 0, 1, 0);
        // Repeated insert of key zero runs out of levels.
        add_row(rhht_pkg::OP_INSERT, 64'd0, 0, 1, 0, 0, 0, 1);
        add_row(rhht_pkg::OP_LOOKUP, 64'd0, 0, 1, 0, 0, 0, 1);
        add_row(rhht_pkg::OP_REMOVE, 64'd0, 0, 1, 0, 0, 0, 1);
        add_row(rhht_pkg::OP_INSERT, '1, 0, 0, 0, 0, 0, 0);
        add_row(rhht_pkg::OP_SET,    '1, -1, 0, 0, 0, 0, 0);
        add_row(rhht_pkg::OP_LOOKUP, '1, 0, 0, 0, 0, 0, 0);
        add_row(rhht_pkg::OP_SET,    '1, 8191, 0, 0, 0, 0, 0);
        add_row(rhht_pkg::OP_LOOKUP, '1, 0, 0, 0, 0, 0, 0);
        // Keys one apart by a multiple of 2^43 collide at every level.
        add_row(rhht_pkg::OP_INSERT, 64'd1, 0, 0, 0, 0, 0, 0);
        add_row(rhht_pkg::OP_SET,    64'd1 + (64'd1 << 43), 5, 0, 0, 0, 0, 0);
        add_row(rhht_pkg::OP_LOOKUP, 64'd1 + (64'd1 << 43), 0, 0, 0, 0, 0, 0);
        add_row(rhht_pkg::OP_INSERT, 64'd1 + (64'd1 << 40), 0, 0, 0, 0, 0, 0);
        add_row(rhht_pkg::OP_INSERT, 64'd1 + (64'd1 << 43), 0, 0, 0, 0, 0, 0);
        add_row(rhht_pkg::OP_REMOVE, 64'd1 + (64'd3 << 43), 0, 0, 0, 0, 0, 0);
        add_row(rhht_pkg::OP_LOOKUP, 64'd1, 0, 0, 0, 0, 0, 0);
        add_row(rhht_pkg::OP_INSERT, 64'h5555_5555_5555_5555, 0, 0, 0, 0, 0, 0);
        add_row(rhht_pkg::OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 0, 0, 0, 0, 0, 0);
        add_row(rhht_pkg::OP_REMOVE, '1, 0, 0, 0, 0, 0, 0);

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_words[i])
        begin
            send_word(directed_words[i].op, directed_words[i].k, directed_words[i].nv,
                      directed_words[i].typed, directed_words[i].ans);
            idle_burst(1'b1);
        end

        family_base = {$urandom, $urandom};
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if ($urandom_range(0, 99) == 0)
                family_base = {$urandom, $urandom};
            pick = $urandom_range(0, 99);
            if (pick < 35)
                op = rhht_pkg::OP_INSERT;
            else if (pick < 55)
                op = rhht_pkg::OP_SET;
            else if (pick < 80)
                op = rhht_pkg::OP_LOOKUP;
            else
                op = rhht_pkg::OP_REMOVE;
            send_word(op, pick_key(family_base),
                      14'($urandom_range(0, 8192) - 1), 1'b0, none);
            idle_burst(n < RANDOM_WORDS - CALM_WORDS);
        end
        start <= 1'b0;

        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (400)
            @(posedge clk);
        if (fault_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
